/* sv/rtc_bcd_date_to_unix_seconds_unit_defines.svh */
// assertion macros shared by the rtc date-to-seconds unit
`ifndef RTC_BCD_DATE_TO_UNIX_SECONDS_UNIT_DEFINES_SVH
`define RTC_BCD_DATE_TO_UNIX_SECONDS_UNIT_DEFINES_SVH

// antecedent implies consequent, checked on every rising edge out of reset
`define RBDU_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// condition must never hold out of reset
`define RBDU_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) \
    else $error(msg);

`endif

/* sv/rbdu_pkg.sv */
// shared types, constants and calendar tables of the rtc date-to-seconds unit
package rbdu_pkg;

  localparam int EPOCH_W = 38;
  localparam int DAYS_W  = 22;
  localparam int TOD_W   = 17;
  localparam int DOY_W   = 9;
  localparam int YEAR_W  = 14;
  localparam int CENT_W  = 7;

  localparam logic [YEAR_W-1:0] YEAR_BASE   = 14'd1970;
  localparam logic [DAYS_W-1:0] LEAPS_BASE  = 22'd477;   // leap years in 1..1969
  localparam logic [DAYS_W-1:0] DAYS_MAX    = 22'd2932896;
  localparam logic [7:0]        CENT_DFLT   = 8'd20;
  localparam logic [3:0]        MON_FEB     = 4'd2;

  // one decoded snapshot
  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] mon;
    logic [7:0] yy;
    logic [7:0] cent;
  } dec_t;

  // checked fields and partial sums
  typedef struct packed {
    logic              bad;
    logic [DOY_W-1:0]  doy;
    logic [TOD_W-1:0]  tod;
    logic [YEAR_W-1:0] year;
    logic [CENT_W-1:0] cp;
    logic [4:0]        rq;
    logic              after;
  } cal_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [DOY_W-1:0] month_start(input logic [3:0] m);
    logic [DOY_W-1:0] st;
    case (m)
      4'd1:    st = 9'd0;
      4'd2:    st = 9'd31;
      4'd3:    st = 9'd59;
      4'd4:    st = 9'd90;
      4'd5:    st = 9'd120;
      4'd6:    st = 9'd151;
      4'd7:    st = 9'd181;
      4'd8:    st = 9'd212;
      4'd9:    st = 9'd243;
      4'd10:   st = 9'd273;
      4'd11:   st = 9'd304;
      4'd12:   st = 9'd334;
      default: st = 9'd0;
    endcase
    return st;
  endfunction

endpackage

/* sv/rtc_bcd_date_to_unix_seconds_unit.sv */
// top level of the rtc date-to-seconds unit: config register, stage chain, result port
//
// usage
//   input: present one rtc snapshot (seven raw bytes) on the in_raw_* ports and raise
//   start; the transfer happens at a rising edge with start high and busy low. busy
//   is always low, so a new snapshot may be transferred on every cycle.
//   result: out_valid is a one-cycle strobe; out_epoch_seconds and out_fields_invalid
//   are good for that cycle only. the receiver cannot stall, and none is needed since
//   nothing inside the block ever backs up.
//   pipeline: the input transfer passes through the decode, calendar checks, day count and
//   seconds multiply stages in that order before the out_valid strobe (the 22x17 multiply by
//   86400 fills the last stage). throughput: one snapshot per cycle.
//   config: cfg_data is bit 0 of the mode register (1 = binary fields, 0 = packed bcd);
//   cfg_ready is always high. write it only when no snapshot is in flight.
//   reset: synchronous, active low; clears the pipeline valid bits and selects bcd
//   mode. there is no clearing pass; the block is ready on the first cycle after reset.
module rtc_bcd_date_to_unix_seconds_unit
  import rbdu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // snapshot input
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         in_raw_second,
  input  logic [7:0]         in_raw_minute,
  input  logic [7:0]         in_raw_hour,
  input  logic [7:0]         in_raw_day,
  input  logic [7:0]         in_raw_month,
  input  logic [7:0]         in_raw_year,
  input  logic [7:0]         in_raw_century,
  // result strobe
  output logic               out_valid,
  output logic [EPOCH_W-1:0] out_epoch_seconds,
  output logic               out_fields_invalid,
  // mode register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  `include "rtc_bcd_date_to_unix_seconds_unit_defines.svh"

  logic binary_mode_r;
  logic binary_mode_nxt;
  logic in_fire;
  logic dec_valid;
  dec_t dec;
  logic cal_valid;
  cal_t cal;

  // every stage moves forward every cycle, so the input never backs up
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_fire   = start && !busy;

  // mode register: only bit 0 of the write is kept
  assign binary_mode_nxt = (cfg_valid && cfg_ready) ? cfg_data : binary_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      binary_mode_r <= 1'b0;
    end else begin
      binary_mode_r <= binary_mode_nxt;
    end
  end

  // stage 1: byte decode
  rbdu_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .binary_mode (binary_mode_r),
    .raw_second  (in_raw_second),
    .raw_minute  (in_raw_minute),
    .raw_hour    (in_raw_hour),
    .raw_day     (in_raw_day),
    .raw_month   (in_raw_month),
    .raw_year    (in_raw_year),
    .raw_century (in_raw_century),
    .dec_valid   (dec_valid),
    .dec         (dec)
  );

  // stage 2: checks and within-year offsets
  rbdu_calendar u_calendar (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (dec_valid),
    .dec       (dec),
    .cal_valid (cal_valid),
    .cal       (cal)
  );

  // stages 3 and 4: days since the epoch, then seconds; invalid results forced to zero
  rbdu_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .cal_valid   (cal_valid),
    .cal         (cal),
    .res_valid   (out_valid),
    .res_seconds (out_epoch_seconds),
    .res_invalid (out_fields_invalid)
  );

  // each transfer shows up as one out_valid strobe, and each strobe has a transfer behind it
  `RBDU_ASSERT_IMP(a_fire_gives_result, clk, rst_n, in_fire, ##4 out_valid, "input transfer lost in pipeline")
  `RBDU_ASSERT_IMP(a_result_has_source, clk, rst_n, out_valid, $past(in_fire, 4), "result without input transfer")
  `RBDU_ASSERT_NEVER(a_invalid_is_zero, clk, rst_n, out_valid && out_fields_invalid && (out_epoch_seconds != '0), "invalid result carries nonzero seconds")

endmodule

/* sv/rbdu_decode.sv */
// stage 1: bcd or binary decode of the raw rtc bytes
module rbdu_decode
  import rbdu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       binary_mode,
  input  logic [7:0] raw_second,
  input  logic [7:0] raw_minute,
  input  logic [7:0] raw_hour,
  input  logic [7:0] raw_day,
  input  logic [7:0] raw_month,
  input  logic [7:0] raw_year,
  input  logic [7:0] raw_century,
  output logic       dec_valid,
  output dec_t       dec
);

  logic dec_valid_r;
  dec_t dec_r;
  dec_t dec_nxt;

  function automatic logic [7:0] decode_byte(input logic [7:0] b, input logic bin);
    logic [7:0] hi;
    hi = {4'd0, b[7:4]};
    return bin ? b : (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
  endfunction

  always_comb begin
    dec_nxt.sec  = decode_byte(raw_second, binary_mode);
    dec_nxt.min  = decode_byte(raw_minute, binary_mode);
    dec_nxt.hour = decode_byte(raw_hour, binary_mode);
    dec_nxt.day  = decode_byte(raw_day, binary_mode);
    dec_nxt.mon  = decode_byte(raw_month, binary_mode);
    dec_nxt.yy   = decode_byte(raw_year, binary_mode);
    // zero century byte means the 2000s
    dec_nxt.cent = (raw_century == 8'd0) ? CENT_DFLT : decode_byte(raw_century, binary_mode);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_valid_r <= 1'b0;
    end else begin
      dec_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dec_r <= dec_nxt;
    end
  end

  assign dec_valid = dec_valid_r;
  assign dec       = dec_r;

endmodule

/* sv/rbdu_calendar.sv */
// stage 2: range checks, leap rule, day of year, time of day, century split
module rbdu_calendar
  import rbdu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic dec_valid,
  input  dec_t dec,
  output logic cal_valid,
  output cal_t cal
);

  logic              cal_valid_r;
  cal_t              cal_r;
  cal_t              cal_nxt;
  logic [3:0]        mon4;
  logic              mon_ok;
  logic              leap;
  logic [4:0]        dim;
  logic [CENT_W-1:0] yy7;
  logic [CENT_W-1:0] cent7;
  logic [CENT_W-1:0] r7;

  always_comb begin
    mon4   = dec.mon[3:0];
    mon_ok = (dec.mon >= 8'd1) && (dec.mon <= 8'd12);
    yy7    = dec.yy[CENT_W-1:0];
    cent7  = dec.cent[CENT_W-1:0];
    // year % 4 follows the two digits, a century year follows the century
    leap   = (yy7 != 7'd0) ? (yy7[1:0] == 2'd0) : (cent7[1:0] == 2'd0);
    dim    = month_len(mon4) + {4'd0, (mon4 == MON_FEB) && leap};

    cal_nxt.bad = (dec.sec > 8'd59) || (dec.min > 8'd59) || (dec.hour > 8'd23) ||
                  (dec.yy > 8'd99) || (dec.cent > 8'd99) || !mon_ok ||
                  (dec.day == 8'd0) || (dec.day > {3'd0, dim});

    cal_nxt.doy = month_start(mon4) + {8'd0, (mon4 > MON_FEB) && leap} +
                  {4'd0, dec.day[4:0]} - 9'd1;
    cal_nxt.tod = {12'd0, dec.hour[4:0]} * 17'd3600 + {11'd0, dec.min[5:0]} * 17'd60 +
                  {11'd0, dec.sec[5:0]};

    cal_nxt.year  = {7'd0, cent7} * 14'd100 + {7'd0, yy7};
    cal_nxt.after = cal_nxt.year > YEAR_BASE;

    // year - 1 split into century cp and remainder r7
    cal_nxt.cp = (yy7 == 7'd0) ? cent7 - 7'd1 : cent7;
    r7         = (yy7 == 7'd0) ? 7'd99 : yy7 - 7'd1;
    cal_nxt.rq = r7[6:2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_valid_r <= 1'b0;
    end else begin
      cal_valid_r <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_valid) begin
      cal_r <= cal_nxt;
    end
  end

  assign cal_valid = cal_valid_r;
  assign cal       = cal_r;

endmodule

/* sv/rbdu_accum.sv */
// stages 3 and 4: whole-year days, total days, scaling to seconds
module rbdu_accum
  import rbdu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cal_valid,
  input  cal_t               cal,
  output logic               res_valid,
  output logic [EPOCH_W-1:0] res_seconds,
  output logic               res_invalid
);

  `include "rtc_bcd_date_to_unix_seconds_unit_defines.svh"

  logic               s3_valid_r;
  logic               s3_bad_r;
  logic [DAYS_W-1:0]  s3_days_r;
  logic [DAYS_W-1:0]  s3_days_nxt;
  logic [TOD_W-1:0]   s3_tod_r;
  logic [11:0]        lp;
  logic [12:0]        yspan;
  logic [DAYS_W-1:0]  ydays;
  logic               s4_valid_r;
  logic               s4_bad_r;
  logic [EPOCH_W-1:0] s4_secs_r;
  logic [EPOCH_W-1:0] s4_secs_nxt;
  logic [EPOCH_W:0]   prod;

  always_comb begin
    // leap years in 1..year-1, no division needed
    lp    = {5'd0, cal.cp} * 12'd24 + {7'd0, cal.rq} + {7'd0, cal.cp[6:2]};
    yspan = 13'(cal.year - YEAR_BASE);
    ydays = {9'd0, yspan} * 22'd365 + {10'd0, lp} - LEAPS_BASE;
    s3_days_nxt = (cal.after ? ydays : '0) + {13'd0, cal.doy};
  end

  always_comb begin
    prod        = {17'd0, s3_days_r} * 39'd86400 + {22'd0, s3_tod_r};
    s4_secs_nxt = s3_bad_r ? '0 : prod[EPOCH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= cal_valid;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cal_valid) begin
      s3_bad_r  <= cal.bad;
      s3_days_r <= s3_days_nxt;
      s3_tod_r  <= cal.tod;
    end
    if (s3_valid_r) begin
      s4_bad_r  <= s3_bad_r;
      s4_secs_r <= s4_secs_nxt;
    end
  end

  assign res_valid   = s4_valid_r;
  assign res_seconds = s4_secs_r;
  assign res_invalid = s4_bad_r;

  `RBDU_ASSERT_IMP(a_days_in_range, clk, rst_n, s3_valid_r && !s3_bad_r, s3_days_r <= DAYS_MAX, "day count beyond year 9999")

endmodule
